// ===== design/pmhd_pkg.sv =====
// pmhd_pkg: types and constants for the ps/2 mouse host decoder
// no dependencies; imported by every module of the block
`default_nettype none

package pmhd_pkg;

  // mouse to host bytes
  localparam logic [7:0] BYTE_SELFTEST_OK = 8'hAA;
  localparam logic [7:0] BYTE_ACK         = 8'hFA;

  // host to mouse commands
  localparam logic [7:0] CMD_STREAM = 8'hEA;
  localparam logic [7:0] CMD_REMOTE = 8'hF0;
  localparam logic [7:0] CMD_READ   = 8'hEB;
  localparam logic [7:0] CMD_NONE   = 8'h00;

  // status byte bit positions
  localparam int unsigned STS_LEFT   = 0;
  localparam int unsigned STS_RIGHT  = 1;
  localparam int unsigned STS_MIDDLE = 2;
  localparam int unsigned STS_XSIGN  = 4;
  localparam int unsigned STS_YSIGN  = 5;

  localparam int unsigned OUT_POS_W = 16;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_BAT        = 4'd0,
    PH_ID         = 4'd1,
    PH_STREAM_ACK = 4'd2,
    PH_REMOTE_ACK = 4'd3,
    PH_POLL_ACK   = 4'd4,
    PH_STATUS     = 4'd5,
    PH_DX         = 4'd6,
    PH_DY         = 4'd7,
    PH_FAILED     = 4'd8
  } phase_e;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       selftest_ok;
    logic       is_ack;
  } item_t;

  typedef struct packed {
    logic                 send_valid;
    logic [7:0]           send_byte;
    logic                 report_valid;
    logic [OUT_POS_W-1:0] pos_x;
    logic [OUT_POS_W-1:0] pos_y;
    logic                 left_button;
    logic                 middle_button;
    logic                 right_button;
    logic                 remote_active;
    logic                 link_failed;
  } result_t;

endpackage

`default_nettype wire

// ===== design/pmhd_fifo.sv =====
// pmhd_fifo: two-entry word queue with push/full and pop/empty sides
// depends on pmhd_pkg for depth and pointer widths
`default_nettype none

module pmhd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  import pmhd_pkg::*;

  logic [WIDTH-1:0]  mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/pmhd_front.sv =====
// pmhd_front: takes received bytes, tags self-test and ack bytes, queues them
// depends on pmhd_pkg and pmhd_fifo
`default_nettype none

module pmhd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      rx_byte_i,
  output logic            full_o,
  input  logic            item_pop_i,
  output pmhd_pkg::item_t item_o,
  output logic            item_empty_o
);
  import pmhd_pkg::*;

  item_t                in_item;
  logic [$bits(item_t)-1:0] q_rdata;

  always_comb begin
    in_item.rx_byte     = rx_byte_i;
    in_item.selftest_ok = (rx_byte_i == BYTE_SELFTEST_OK);
    in_item.is_ack      = (rx_byte_i == BYTE_ACK);
  end

  pmhd_fifo #(
    .WIDTH($bits(item_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (in_item),
    .full_o  (full_o),
    .pop_i   (item_pop_i),
    .rdata_o (q_rdata),
    .empty_o (item_empty_o)
  );

  assign item_o = q_rdata;

endmodule

`default_nettype wire

// ===== design/pmhd_back.sv =====
// pmhd_back: link bring-up state machine, packet assembly and position accumulators
// depends on pmhd_pkg
`default_nettype none

module pmhd_back #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmhd_pkg::item_t   item_i,
  input  logic              item_empty_i,
  output logic              item_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output pmhd_pkg::result_t res_o
);
  import pmhd_pkg::*;

  phase_e               phase_q, phase_d;
  logic                 remote_q, remote_d;
  logic [7:0]           status_q, status_d;
  logic [7:0]           dx_q, dx_d;
  logic [POS_WIDTH-1:0] x_q, x_d;
  logic [POS_WIDTH-1:0] y_q, y_d;
  logic [2:0]           btn_q, btn_d;
  logic                 fire;
  logic                 send_v;
  logic [7:0]           send_b;
  logic                 rep;
  logic [POS_WIDTH-1:0] dx_ext, dy_ext;
  logic [31:0]          x_wide, y_wide;

  assign fire       = !item_empty_i && !res_full_i;
  assign item_pop_o = fire;
  assign res_push_o = fire;

  // sign bits live in the status byte, not in the delta bytes
  assign dx_ext = {{(POS_WIDTH-8){status_q[STS_XSIGN]}}, dx_q};
  assign dy_ext = {{(POS_WIDTH-8){status_q[STS_YSIGN]}}, item_i.rx_byte};

  always_comb begin
    phase_d  = phase_q;
    remote_d = remote_q;
    status_d = status_q;
    dx_d     = dx_q;
    x_d      = x_q;
    y_d      = y_q;
    btn_d    = btn_q;
    send_v   = 1'b0;
    send_b   = CMD_NONE;
    rep      = 1'b0;
    unique case (phase_q)
      PH_BAT: begin
        phase_d = item_i.selftest_ok ? PH_ID : PH_FAILED;
      end
      PH_ID: begin
        send_v  = 1'b1;
        send_b  = CMD_STREAM;
        phase_d = PH_STREAM_ACK;
      end
      PH_STREAM_ACK: begin
        if (item_i.is_ack) begin
          phase_d = PH_STATUS;
        end else begin
          send_v   = 1'b1;
          send_b   = CMD_REMOTE;
          remote_d = 1'b1;
          phase_d  = PH_REMOTE_ACK;
        end
      end
      PH_REMOTE_ACK: begin
        send_v  = 1'b1;
        send_b  = CMD_READ;
        phase_d = PH_POLL_ACK;
      end
      PH_POLL_ACK: begin
        if (item_i.is_ack) begin
          phase_d = PH_STATUS;
        end else begin
          send_v = 1'b1;
          send_b = CMD_READ;
        end
      end
      PH_STATUS: begin
        status_d = item_i.rx_byte;
        phase_d  = PH_DX;
      end
      PH_DX: begin
        dx_d    = item_i.rx_byte;
        phase_d = PH_DY;
      end
      PH_DY: begin
        x_d   = x_q + dx_ext;
        y_d   = y_q + dy_ext;
        btn_d = {status_q[STS_RIGHT], status_q[STS_MIDDLE], status_q[STS_LEFT]};
        rep   = 1'b1;
        if (remote_q) begin
          send_v  = 1'b1;
          send_b  = CMD_READ;
          phase_d = PH_POLL_ACK;
        end else begin
          phase_d = PH_STATUS;
        end
      end
      default: begin
        phase_d = PH_FAILED;
      end
    endcase
  end

  assign x_wide = 32'(x_d);
  assign y_wide = 32'(y_d);

  always_comb begin
    res_o.send_valid    = send_v;
    res_o.send_byte     = send_b;
    res_o.report_valid  = rep;
    res_o.pos_x         = x_wide[OUT_POS_W-1:0];
    res_o.pos_y         = y_wide[OUT_POS_W-1:0];
    res_o.left_button   = btn_d[0];
    res_o.middle_button = btn_d[1];
    res_o.right_button  = btn_d[2];
    res_o.remote_active = remote_d;
    res_o.link_failed   = (phase_d == PH_FAILED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BAT;
      remote_q <= 1'b0;
      status_q <= '0;
      dx_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      btn_q    <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      remote_q <= remote_d;
      status_q <= status_d;
      dx_q     <= dx_d;
      x_q      <= x_d;
      y_q      <= y_d;
      btn_q    <= btn_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2_mouse_host_decoder.sv =====
// ps2_mouse_host_decoder: host side ps/2 mouse byte decoder, one result word per byte
// a pushed byte is registered in the front queue, and its result word in the result queue
// throughput: one byte per cycle while the result queue is not full, set by the back-end state machine
// two-entry queues sit between input, back end and result side
// reset: asynchronous active low; waits for the self-test byte, positions zero
// depends on pmhd_pkg, pmhd_front, pmhd_back, pmhd_fifo
`default_nettype none

module ps2_mouse_host_decoder #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic               send_valid_o,
  output logic [7:0]         send_byte_o,
  output logic               report_valid_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic               left_button_o,
  output logic               middle_button_o,
  output logic               right_button_o,
  output logic               remote_active_o,
  output logic               link_failed_o
);
  import pmhd_pkg::*;

  item_t                      item;
  logic                       item_empty;
  logic                       item_pop;
  logic                       res_full;
  logic                       res_push;
  result_t                    res_in;
  logic [$bits(result_t)-1:0] res_rdata;
  result_t                    res_out;

  pmhd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .rx_byte_i    (rx_byte_i),
    .full_o       (full),
    .item_pop_i   (item_pop),
    .item_o       (item),
    .item_empty_o (item_empty)
  );

  pmhd_back #(
    .POS_WIDTH(POS_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  pmhd_fifo #(
    .WIDTH($bits(result_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out         = res_rdata;
  assign send_valid_o    = res_out.send_valid;
  assign send_byte_o     = res_out.send_byte;
  assign report_valid_o  = res_out.report_valid;
  assign pos_x_o         = res_out.pos_x;
  assign pos_y_o         = res_out.pos_y;
  assign left_button_o   = res_out.left_button;
  assign middle_button_o = res_out.middle_button;
  assign right_button_o  = res_out.right_button;
  assign remote_active_o = res_out.remote_active;
  assign link_failed_o   = res_out.link_failed;

endmodule

`default_nettype wire

// ===== design/pmhd_checker.sv =====
// pmhd_checker: port-level assertions for ps2_mouse_host_decoder, bound to the top level
// depends on pmhd_pkg for command codes
`default_nettype none

module pmhd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty,
  input  logic        pop,
  input  logic        send_valid_o,
  input  logic [7:0]  send_byte_o,
  input  logic        report_valid_o,
  input  logic [15:0] pos_x_o,
  input  logic [15:0] pos_y_o,
  input  logic        remote_active_o,
  input  logic        link_failed_o
);
  import pmhd_pkg::*;

  logic taken;
  logic seen_failed_q;
  logic seen_remote_q;

  assign taken = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_failed_q <= 1'b0;
      seen_remote_q <= 1'b0;
    end else if (taken) begin
      seen_failed_q <= seen_failed_q || link_failed_o;
      seen_remote_q <= seen_remote_q || remote_active_o;
    end
  end

  // a failed link stays failed and goes quiet
  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && seen_failed_q) |-> (link_failed_o && !send_valid_o && !report_valid_o))
    else $error("link failure not sticky");

  // remote mode is never left once entered
  a_remote_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && seen_remote_q) |-> remote_active_o)
    else $error("remote mode dropped");

  a_send_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (send_valid_o ? (send_byte_o == CMD_STREAM || send_byte_o == CMD_REMOTE ||
                               send_byte_o == CMD_READ)
                             : (send_byte_o == CMD_NONE)))
    else $error("bad command byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pos_x_o) && $stable(pos_y_o) &&
                          $stable(send_byte_o)))
    else $error("waiting result changed");

endmodule

bind ps2_mouse_host_decoder pmhd_checker u_pmhd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .send_valid_o    (send_valid_o),
  .send_byte_o     (send_byte_o),
  .report_valid_o  (report_valid_o),
  .pos_x_o         (pos_x_o),
  .pos_y_o         (pos_y_o),
  .remote_active_o (remote_active_o),
  .link_failed_o   (link_failed_o)
);

`default_nettype wire
